// ===== rtl/mdl_pkg.sv =====
package mdl_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int QB         = 33;
    localparam int MAG_W      = QB;
    localparam int NUM_W      = 96 + 2 * FRAC_BITS;
    localparam int DEN_W      = 127;
    localparam int FRONT_LAT  = 5;
    localparam int LANE_LAT   = QB + 2;
    localparam int PIPE_LAT   = FRONT_LAT + LANE_LAT + 1;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;
    localparam int DRS_W      = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_RADIUS_SQ  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_FACTOR   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_STRENGTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_DENSITY = CFG_IDX_W'(3);

    localparam logic [DRS_W-1:0] DRS_RESET = DRS_W'(1) << FRAC_BITS;
    localparam logic [31:0]      ONE_Q     = 32'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] theta_x;
        logic signed [31:0] theta_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] alpha_x;
        logic signed [31:0] alpha_y;
        logic signed [31:0] deriv_xx;
        logic signed [31:0] deriv_yy;
        logic signed [31:0] deriv_xy;
        logic signed [31:0] density_out;
        logic               is_inside;
        logic               zero_radius;
    } t_res;

    typedef struct packed {
        logic [DEN_W-1:0] r;
        logic [DEN_W-1:0] den;
        logic [QB-1:0]    low;
        logic [QB-1:0]    q;
        logic             ovf;
    } t_div;

    typedef struct packed {
        logic             in_disk;
        logic             zr;
        logic             nx;
        logic             ny;
        logic             nd;
        logic [MAG_W-1:0] ain_x;
        logic [MAG_W-1:0] ain_y;
    } t_sb;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [MAG_W-1:0] clamp_mag(input logic [63:0] v);
        return (|v[63:MAG_W]) ? {MAG_W{1'b1}} : v[MAG_W-1:0];
    endfunction

    function automatic logic [31:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic big;
        big = |mag[MAG_W-1:31];
        if (neg) begin
            return big ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end
        return big ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

endpackage

// ===== rtl/mdl_div_cell.sv =====
module mdl_div_cell (
    input  logic          i_clk,
    input  mdl_pkg::t_div i_d,
    output mdl_pkg::t_div o_d
);
    import mdl_pkg::*;

    logic [DEN_W:0] t;
    logic           ge;
    t_div           n_d;
    t_div           r_d;

    always_comb begin
        t          = {i_d.r, i_d.low[QB-1]};
        ge         = t >= {1'b0, i_d.den};
        n_d        = i_d;
        n_d.r      = ge ? DEN_W'(t - {1'b0, i_d.den}) : DEN_W'(t);
        n_d.low    = {i_d.low[QB-2:0], 1'b0};
        n_d.q      = {i_d.q[QB-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

// ===== rtl/mdl_div_lane.sv =====
module mdl_div_lane (
    input  logic                       i_clk,
    input  logic [mdl_pkg::NUM_W-1:0]  i_num,
    input  logic [mdl_pkg::DEN_W-1:0]  i_den,
    output logic [mdl_pkg::MAG_W-1:0]  o_mag
);
    import mdl_pkg::*;

    t_div             s [QB+1];
    t_div             n_s0;
    t_div             r_s0;
    logic [QB:0]      rnd;
    logic [MAG_W-1:0] r_mag;

    always_comb begin
        n_s0.ovf = (NUM_W + QB)'(i_num) >= ((NUM_W + QB)'(i_den) << QB);
        n_s0.r   = DEN_W'(i_num >> QB);
        n_s0.den = i_den;
        n_s0.low = i_num[QB-1:0];
        n_s0.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
    end

    assign s[0] = r_s0;

    for (genvar k = 0; k < QB; k++) begin : g_cell
        mdl_div_cell u_cell (
            .i_clk (i_clk),
            .i_d   (s[k]),
            .o_d   (s[k+1])
        );
    end

    assign rnd = ({1'b0, s[QB].q} + (QB+1)'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        r_mag <= s[QB].ovf ? {MAG_W{1'b1}} : rnd[MAG_W-1:0];
    end

    assign o_mag = r_mag;

endmodule

// ===== rtl/mass_disk_lens_deflection_top.sv =====
// channel | direction | handshake                  | word
// input   | in        | start & !busy              | i_in (theta_x, theta_y)
// result  | out       | o_res_valid, one cycle     | o_res
// config  | in        | i_cfg_valid & o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word accepted every cycle; busy is never raised.
// Each result passes five front stages (magnitudes, 32x32 multiplies, sums), then a
// chain of 33 restoring divide cells plus check and round, then the output register.
// Synchronous active-low reset clears valids and loads register defaults.
// The receiver cannot stall. The user must change configuration only when the pipe
// is empty; the block itself does not enforce this.
module mass_disk_lens_deflection_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mdl_pkg::t_in                   i_in,
    output logic                           o_res_valid,
    output mdl_pkg::t_res                  o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mdl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mdl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mdl_pkg::*;

    logic [DRS_W-1:0] r_drs;
    logic [31:0]      r_inf;
    logic [31:0]      r_pts;
    logic [31:0]      r_den;
    logic [31:0]      ms;
    logic [31:0]      mf;
    logic             ns;
    logic             nf;

    logic [FRONT_LAT-1:0] r_vld;
    logic [LANE_LAT-1:0]  r_vq;
    logic                 acc;

    logic [31:0] r1_mx, r1_my;
    logic        r1_nx, r1_ny;

    logic [63:0] r2_x2, r2_y2, r2_ax, r2_ay, r2_axy, r2_fx, r2_fy;
    logic        r2_nx, r2_ny;

    logic [63:0] s3_r2, s3_rx, s3_ry;
    logic        s3_in;
    logic [63:0] r3_r2, r3_diff, r3_ax, r3_ay, r3_sxy_lo, r3_sxy_hi;
    t_sb         r3_sb;

    logic [63:0] r4_pll, r4_plh, r4_phh, r4_sd_lo, r4_sd_hi, r4_r2, r4_ax, r4_ay;
    logic [95:0] r4_sxy;
    t_sb         r4_sb;

    logic [127:0] r5_den2;
    logic [95:0]  r5_sd, r5_sxy;
    logic [63:0]  r5_r2, r5_ax, r5_ay;
    t_sb          r5_sb;

    t_sb          r_sbq [LANE_LAT];
    t_sb          sb;
    logic [MAG_W-1:0] m_ax, m_ay, m_dd, m_dxy;

    t_res n_res;
    t_res r_res;
    logic r_res_valid;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc         = start & !busy;

    assign ms = abs32(r_pts);
    assign ns = r_pts[31];
    assign mf = abs32(r_inf);
    assign nf = r_inf[31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drs <= DRS_RESET;
            r_inf <= ONE_Q;
            r_pts <= ONE_Q;
            r_den <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DISK_RADIUS_SQ:  r_drs <= i_cfg_data[DRS_W-1:0];
                CFG_INSIDE_FACTOR:   r_inf <= i_cfg_data[31:0];
                CFG_POINT_STRENGTH:  r_pts <= i_cfg_data[31:0];
                CFG_SURFACE_DENSITY: r_den <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_vq        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_vld       <= {r_vld[FRONT_LAT-2:0], acc};
            r_vq        <= {r_vq[LANE_LAT-2:0], r_vld[FRONT_LAT-1]};
            r_res_valid <= r_vq[LANE_LAT-1];
        end
    end

    always_comb begin
        s3_r2 = r2_x2 + r2_y2;
        s3_in = (s3_r2 >> FRAC_BITS) < 64'(r_drs);
        s3_rx = (r2_fx + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        s3_ry = (r2_fy + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        r1_mx <= abs32(i_in.theta_x);
        r1_my <= abs32(i_in.theta_y);
        r1_nx <= i_in.theta_x[31];
        r1_ny <= i_in.theta_y[31];

        r2_x2  <= 64'(r1_mx) * 64'(r1_mx);
        r2_y2  <= 64'(r1_my) * 64'(r1_my);
        r2_ax  <= 64'(ms) * 64'(r1_mx);
        r2_ay  <= 64'(ms) * 64'(r1_my);
        r2_axy <= 64'(r1_mx) * 64'(r1_my);
        r2_fx  <= 64'(mf) * 64'(r1_mx);
        r2_fy  <= 64'(mf) * 64'(r1_my);
        r2_nx  <= r1_nx;
        r2_ny  <= r1_ny;

        r3_r2         <= s3_r2;
        r3_diff       <= (r2_x2 > r2_y2) ? (r2_x2 - r2_y2) : (r2_y2 - r2_x2);
        r3_ax         <= r2_ax;
        r3_ay         <= r2_ay;
        r3_sxy_lo     <= 64'(ms) * 64'(r2_axy[31:0]);
        r3_sxy_hi     <= 64'(ms) * 64'(r2_axy[63:32]);
        r3_sb.in_disk <= s3_in;
        r3_sb.zr      <= !s3_in && (s3_r2 == 64'd0);
        r3_sb.nx      <= r2_nx;
        r3_sb.ny      <= r2_ny;
        r3_sb.nd      <= r2_x2 > r2_y2;
        r3_sb.ain_x   <= clamp_mag(s3_rx);
        r3_sb.ain_y   <= clamp_mag(s3_ry);

        r4_pll   <= 64'(r3_r2[31:0]) * 64'(r3_r2[31:0]);
        r4_plh   <= 64'(r3_r2[31:0]) * 64'(r3_r2[63:32]);
        r4_phh   <= 64'(r3_r2[63:32]) * 64'(r3_r2[63:32]);
        r4_sd_lo <= 64'(ms) * 64'(r3_diff[31:0]);
        r4_sd_hi <= 64'(ms) * 64'(r3_diff[63:32]);
        r4_sxy   <= 96'(r3_sxy_lo) + {r3_sxy_hi, 32'd0};
        r4_r2    <= r3_r2;
        r4_ax    <= r3_ax;
        r4_ay    <= r3_ay;
        r4_sb    <= r3_sb;

        r5_den2 <= 128'(r4_pll) + {31'd0, r4_plh, 33'd0} + {r4_phh, 64'd0};
        r5_sd   <= 96'(r4_sd_lo) + {r4_sd_hi, 32'd0};
        r5_sxy  <= r4_sxy;
        r5_r2   <= r4_r2;
        r5_ax   <= r4_ax;
        r5_ay   <= r4_ay;
        r5_sb   <= r4_sb;

        r_sbq[0] <= r5_sb;
        for (int i = 1; i < LANE_LAT; i++) begin
            r_sbq[i] <= r_sbq[i-1];
        end

        r_res <= n_res;
    end

    mdl_div_lane u_lane_ax (
        .i_clk (i_clk),
        .i_num (NUM_W'(r5_ax) << (FRAC_BITS + 1)),
        .i_den (DEN_W'(r5_r2)),
        .o_mag (m_ax)
    );

    mdl_div_lane u_lane_ay (
        .i_clk (i_clk),
        .i_num (NUM_W'(r5_ay) << (FRAC_BITS + 1)),
        .i_den (DEN_W'(r5_r2)),
        .o_mag (m_ay)
    );

    mdl_div_lane u_lane_dd (
        .i_clk (i_clk),
        .i_num (NUM_W'(r5_sd) << (2 * FRAC_BITS + 1)),
        .i_den (r5_den2[DEN_W-1:0]),
        .o_mag (m_dd)
    );

    mdl_div_lane u_lane_dxy (
        .i_clk (i_clk),
        .i_num (NUM_W'(r5_sxy) << (2 * FRAC_BITS + 2)),
        .i_den (r5_den2[DEN_W-1:0]),
        .o_mag (m_dxy)
    );

    assign sb = r_sbq[LANE_LAT-1];

    always_comb begin
        n_res = '0;
        if (sb.in_disk) begin
            n_res.alpha_x     = sat_mag(sb.nx ^ nf, sb.ain_x);
            n_res.alpha_y     = sat_mag(sb.ny ^ nf, sb.ain_y);
            n_res.deriv_xx    = r_inf;
            n_res.deriv_yy    = r_inf;
            n_res.density_out = r_den;
            n_res.is_inside   = 1'b1;
        end else if (sb.zr) begin
            n_res.alpha_x     = sat_mag(ns, {MAG_W{1'b1}});
            n_res.alpha_y     = sat_mag(ns, {MAG_W{1'b1}});
            n_res.deriv_xx    = sat_mag(ns, {MAG_W{1'b1}});
            n_res.deriv_yy    = sat_mag(ns, {MAG_W{1'b1}});
            n_res.deriv_xy    = sat_mag(ns, {MAG_W{1'b1}});
            n_res.zero_radius = 1'b1;
        end else begin
            n_res.alpha_x  = sat_mag(ns ^ sb.nx, m_ax);
            n_res.alpha_y  = sat_mag(ns ^ sb.ny, m_ay);
            n_res.deriv_xx = sat_mag(ns ^ sb.nd, m_dd);
            n_res.deriv_yy = sat_mag(!(ns ^ sb.nd), m_dd);
            n_res.deriv_xy = sat_mag(!(ns ^ sb.nx ^ sb.ny), m_dxy);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== rtl/mdl_chk.sv =====
module mdl_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_res_valid,
    input mdl_pkg::t_res o_res
);
    import mdl_pkg::*;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result without matching input word");

    a_zr_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.zero_radius |-> !o_res.is_inside && o_res.density_out == 32'sd0)
        else $error("zero radius flagged inside disk");

    a_zr_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.zero_radius |->
            o_res.alpha_x == o_res.alpha_y && o_res.deriv_xx == o_res.deriv_yy)
        else $error("zero radius results not saturated alike");

    a_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.is_inside |->
            o_res.deriv_xy == 32'sd0 && o_res.deriv_xx == o_res.deriv_yy)
        else $error("inside derivatives inconsistent");

endmodule

bind mass_disk_lens_deflection_top mdl_chk u_mdl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
